// ===== rtl/stopt_pkg.sv =====
`timescale 1ns / 1ps

package stopt_pkg;

    // Field widths
    localparam int POS_W  = 64;
    localparam int SLOT_W = 4;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;

    // Slots that slot_index and assigned_slot can name
    localparam int ADDRESSABLE_SLOTS = 16;

    // Reset value of the active slot count
    localparam logic [CNT_W-1:0] ACTIVE_RESET = 5'd10;

    // Register byte addresses
    localparam logic [2:0] ADDR_ACTIVE_SLOTS = 3'd0;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNREGISTER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_ZERO  = 2'd3;

    // What the cells do with a passing token
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_REG   = 2'd1;
    localparam logic [1:0] MODE_UNREG = 2'd2;

    // Token handed from cell to cell
    typedef struct packed {
        logic              go;
        logic [1:0]        mode;
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  pos;
        logic [SLOT_W-1:0] idx;
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  best;
    } t_carry;

endpackage

// ===== rtl/stopt_cell.sv =====
`timescale 1ns / 1ps

module stopt_cell import stopt_pkg::*; #(
    parameter int CELL_ID = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_active,
    input  t_carry i_carry,
    output t_carry o_carry
);

    localparam logic [SLOT_W-1:0] ID = SLOT_W'(CELL_ID);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    t_carry           r_carry;
    t_carry           n_carry;
    logic [POS_W-1:0] w_val;
    logic             w_hit;

    // Value this slot holds once an unregister has gone by
    assign w_hit = (i_carry.idx == ID);
    assign w_val = w_hit ? '0 : r_pos;

    // Act on the token while it sits at this cell
    always_comb begin
        n_pos   = r_pos;
        n_carry = i_carry;
        if (i_carry.go && i_active) begin
            unique case (i_carry.mode)
                MODE_REG: begin
                    // first free active slot takes the position
                    if (!i_carry.found && (r_pos == '0)) begin
                        n_pos         = i_carry.pos;
                        n_carry.found = 1'b1;
                        n_carry.slot  = ID;
                    end
                end
                MODE_UNREG: begin
                    if (w_hit) begin
                        n_pos = '0;
                    end
                    // running minimum over occupied slots
                    if ((w_val != '0) && ((i_carry.best == '0) || (w_val < i_carry.best))) begin
                        n_carry.best = w_val;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_carry.go <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_carry <= n_carry;
        end
    end

    assign o_carry = r_carry;

endmodule

// ===== rtl/slot_table_oldest_position_tracker_core.sv =====
`timescale 1ns / 1ps

// Slot table that tracks the oldest registered position. Every transaction
// sends one token down a row of SLOT_COUNT cells, one cell per clock, each
// cell holding one slot; a register command fills the first free active
// slot, an unregister clears its slot and collects the new minimum on the
// way. A result moves from the last cell into the pending result register
// and from there into the output register; the next transaction is accepted
// only after the result has entered the output register, so the block holds
// one transaction at a time. A result still waiting in the output register
// holds the pending one back and stalls the input for as long as the result
// side stalls.
// active_slots (byte address 0) resets to 10 and is to be written only while
// idle; the block itself does not enforce this.

module slot_table_oldest_position_tracker_core import stopt_pkg::*; #(
    parameter int SLOT_COUNT = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // command channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [POS_W-1:0]   i_start_position,
    input  logic [SLOT_W-1:0]  i_slot_index,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [STAT_W-1:0]  o_status,
    output logic [SLOT_W-1:0]  o_assigned_slot,
    output logic [POS_W-1:0]   o_oldest_position
);

    localparam int MAX_N = (SLOT_COUNT < ADDRESSABLE_SLOTS) ? SLOT_COUNT : ADDRESSABLE_SLOTS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [CNT_W-1:0]  r_active;
    logic [CNT_W-1:0]  w_eff_n;
    logic [POS_W-1:0]  r_oldest;
    logic [POS_W-1:0]  n_oldest;

    logic [STAT_W-1:0] r_res_status;
    logic [SLOT_W-1:0] r_res_slot;
    logic [POS_W-1:0]  r_res_oldest;
    logic [STAT_W-1:0] n_res_status;
    logic [SLOT_W-1:0] n_res_slot;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [SLOT_W-1:0] r_out_slot;
    logic [POS_W-1:0]  r_out_oldest;

    logic              w_accept;
    logic              w_cfg_wr;
    logic              w_load;
    t_carry            w_seed;
    t_carry            w_last;
    t_carry            w_carry  [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] w_active;
    logic [SLOT_COUNT-1:0] w_go;

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr == ADDR_ACTIVE_SLOTS) ? {27'd0, r_active} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (w_cfg_wr && (paddr == ADDR_ACTIVE_SLOTS)) begin
            r_active <= pwdata[CNT_W-1:0];
        end
    end

    // Active count clipped to the slots that exist and can be named
    assign w_eff_n = (r_active > CNT_W'(MAX_N)) ? CNT_W'(MAX_N) : r_active;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    // Token seed: decide range and zero cases up front
    always_comb begin
        w_seed        = '0;
        w_seed.go     = w_accept;
        w_seed.pos    = i_start_position;
        w_seed.idx    = i_slot_index;
        w_seed.mode   = MODE_NONE;
        w_seed.status = STATUS_OK;
        unique case (i_command)
            CMD_REGISTER: begin
                if (i_start_position == '0) begin
                    w_seed.status = STATUS_ZERO;
                end else begin
                    w_seed.mode = MODE_REG;
                end
            end
            CMD_UNREGISTER: begin
                if ({1'b0, i_slot_index} >= w_eff_n) begin
                    w_seed.status = STATUS_RANGE;
                end else begin
                    w_seed.mode = MODE_UNREG;
                end
            end
            default: begin
            end
        endcase
    end

    // Row of slot cells
    for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
        if (i < MAX_N) begin : g_act
            assign w_active[i] = (CNT_W'(i) < w_eff_n);
        end else begin : g_idle
            assign w_active[i] = 1'b0;
        end

        if (i == 0) begin : g_first
            stopt_cell #(.CELL_ID(i)) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_active (w_active[i]),
                .i_carry  (w_seed),
                .o_carry  (w_carry[i])
            );
        end else begin : g_next
            stopt_cell #(.CELL_ID(i)) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_active (w_active[i]),
                .i_carry  (w_carry[i-1]),
                .o_carry  (w_carry[i])
            );
        end

        assign w_go[i] = w_carry[i].go;
    end

    assign w_last = w_carry[SLOT_COUNT-1];

    // Result once the token leaves the row
    always_comb begin
        n_res_status = w_last.status;
        n_res_slot   = '0;
        n_oldest     = r_oldest;
        unique case (w_last.mode)
            MODE_REG: begin
                if (w_last.found) begin
                    n_res_slot = w_last.slot;
                    if ((r_oldest == '0) || (w_last.pos < r_oldest)) begin
                        n_oldest = w_last.pos;
                    end
                end else begin
                    n_res_status = STATUS_FULL;
                end
            end
            MODE_UNREG: begin
                n_oldest = w_last.best;
            end
            default: begin
            end
        endcase
    end

    assign w_load = (r_state == S_HOLD) && (!r_out_valid || i_ready);

    // Control sequence
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_SCAN;
            S_SCAN: if (w_last.go) n_state = S_HOLD;
            S_HOLD: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oldest <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_SCAN) && w_last.go) begin
                r_oldest <= n_oldest;
            end
        end
    end

    // Pending result
    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCAN) && w_last.go) begin
            r_res_status <= n_res_status;
            r_res_slot   <= n_res_slot;
            r_res_oldest <= n_oldest;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_oldest <= r_res_oldest;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_assigned_slot   = r_out_slot;
    assign o_oldest_position = r_out_oldest;

    // Checks
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_go))
        else $error("more than one token in the cell row");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN))
        else $error("accepted transaction did not start a scan");

    a_token_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.go |-> (r_state == S_SCAN))
        else $error("token left the row outside a scan");

    a_oldest_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SCAN) |=> $stable(r_oldest))
        else $error("oldest position changed outside a scan end");

    a_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_valid && (r_state == S_IDLE)))
        else $error("pending result not presented");

endmodule

// ===== tb/slot_table_oldest_position_tracker_core_test.sv =====
`timescale 1ns / 1ps

module slot_table_oldest_position_tracker_core_test import stopt_pkg::*;;

    localparam int SLOT_COUNT       = 16;
    localparam int DRAIN_CYCLES     = SLOT_COUNT + 8;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int RANDOM_PER_PHASE = 130;
    localparam int PHASES           = 8;

    // command code with no function of its own, answered like a query
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // one result transaction as the block should present it
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  oldest;
    } t_answer;

    // Mirror of the slot table: tracks positions, the running minimum and the
    // active slot count, and queues the answer each command should produce.
    class slot_table_mirror;
        logic [POS_W-1:0] slot_pos [SLOT_COUNT];
        logic [POS_W-1:0] oldest;
        logic [CNT_W-1:0] active;
        t_answer          awaited [$];
        int               errors;
        int               checked;
        int               stored;
        int               fulls;
        int               ranges;
        int               zeros;

        function new();
            foreach (slot_pos[i]) slot_pos[i] = '0;
            oldest  = '0;
            active  = ACTIVE_RESET;
            errors  = 0;
            checked = 0;
            stored  = 0;
            fulls   = 0;
            ranges  = 0;
            zeros   = 0;
        endfunction

        // active count clipped to the table and to what a 4-bit index can name
        function int live_slots();
            int n;
            n = int'(active);
            if (n > SLOT_COUNT) n = SLOT_COUNT;
            if (n > ADDRESSABLE_SLOTS) n = ADDRESSABLE_SLOTS;
            return n;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                   logic [SLOT_W-1:0] idx);
            t_answer a;
            int      n;
            bit      placed;
            n        = live_slots();
            a.status = STATUS_OK;
            a.slot   = '0;
            placed   = 1'b0;
            if (cmd == CMD_REGISTER) begin
                if (pos == '0) begin
                    a.status = STATUS_ZERO;
                    zeros++;
                end else begin
                    // lowest free active slot wins
                    for (int i = 0; i < n && !placed; i++) begin
                        if (slot_pos[i] == '0) begin
                            slot_pos[i] = pos;
                            if (oldest == '0 || pos < oldest) oldest = pos;
                            a.slot = i[SLOT_W-1:0];
                            placed = 1'b1;
                        end
                    end
                    if (placed) begin
                        stored++;
                    end else begin
                        a.status = STATUS_FULL;
                        fulls++;
                    end
                end
            end else if (cmd == CMD_UNREGISTER) begin
                if (int'(idx) >= n) begin
                    a.status = STATUS_RANGE;
                    ranges++;
                end else begin
                    // clear, then rescan the active slots for the minimum
                    slot_pos[idx] = '0;
                    oldest = '0;
                    for (int i = 0; i < n; i++) begin
                        if (slot_pos[i] != '0 && (oldest == '0 || slot_pos[i] < oldest))
                            oldest = slot_pos[i];
                    end
                end
            end
            a.oldest = oldest;
            awaited.push_back(a);
        endfunction

        function void check_result(logic [STAT_W-1:0] status, logic [SLOT_W-1:0] slot,
                                   logic [POS_W-1:0] oldest_pos);
            t_answer a;
            if (awaited.size() == 0) begin
                $error("result transaction with no command outstanding");
                errors++;
                return;
            end
            a = awaited.pop_front();
            checked++;
            if (status !== a.status) begin
                $error("status: expected %0d, got %0d", a.status, status);
                errors++;
            end
            if (slot !== a.slot) begin
                $error("assigned_slot: expected %0d, got %0d", a.slot, slot);
                errors++;
            end
            if (oldest_pos !== a.oldest) begin
                $error("oldest_position: expected %0h, got %0h", a.oldest, oldest_pos);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               psel             = 1'b0;
    logic               penable          = 1'b0;
    logic               pwrite           = 1'b0;
    logic [2:0]         paddr            = '0;
    logic [31:0]        pwdata           = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid          = 1'b0;
    logic               o_ready;
    logic [CMD_W-1:0]   i_command        = CMD_QUERY;
    logic [POS_W-1:0]   i_start_position = '0;
    logic [SLOT_W-1:0]  i_slot_index     = '0;
    logic               o_valid;
    logic               i_ready          = 1'b0;
    logic [STAT_W-1:0]  o_status;
    logic [SLOT_W-1:0]  o_assigned_slot;
    logic [POS_W-1:0]   o_oldest_position;

    slot_table_mirror book = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int commands_sent  = 0;
    int quiet_cycles   = 0;

    slot_table_oldest_position_tracker_core #(
        .SLOT_COUNT(SLOT_COUNT)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_command        (i_command),
        .i_start_position (i_start_position),
        .i_slot_index     (i_slot_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_assigned_slot  (o_assigned_slot),
        .o_oldest_position(o_oldest_position)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // result side back-pressure
    always begin
        @(negedge i_clk);
        i_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // compare every accepted result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            book.check_result(o_status, o_assigned_slot, o_oldest_position);
    end

    // watchdog: too long without any transaction on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** slot_table_oldest_position_tracker_core: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one command transaction; entered and left at a falling edge
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic [SLOT_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid          = 1'b1;
        i_command        = cmd;
        i_start_position = pos;
        i_slot_index     = idx;
        do @(posedge i_clk); while (!o_ready);
        book.note_command(cmd, pos, idx);
        commands_sent++;
        @(negedge i_clk);
    endtask

    // mostly registers and releases so the table fills and drains
    task automatic send_random_command();
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  pos;
        logic [SLOT_W-1:0] idx;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 45)      cmd = CMD_REGISTER;
        else if (pick < 80) cmd = CMD_UNREGISTER;
        else if (pick < 94) cmd = CMD_QUERY;
        else                cmd = CMD_UNUSED;
        idx = SLOT_W'($urandom_range(ADDRESSABLE_SLOTS - 1));
        // zero, wide values, small values that collide often, values near the top
        case ($urandom_range(19))
            0:                   pos = '0;
            1, 2, 3, 4, 5, 6, 7: pos = {$urandom, $urandom};
            8, 9, 10, 11, 12, 13, 14, 15:
                                 pos = {32'd0, $urandom_range(1000, 1)};
            default:             pos = '1 - {32'd0, $urandom_range(500)};
        endcase
        send_command(cmd, pos, idx);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // wait for every outstanding result, then let the pipeline settle
    task automatic wait_idle();
        i_valid = 1'b0;
        while (book.awaited.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] readback;
        logic [4:0]  settings [PHASES];
        int          mode;
        settings = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd10, 5'd16};

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed pass at the reset slot count of 10
        send_command(CMD_QUERY, '0, '0);                // empty table
        send_command(CMD_REGISTER, '0, '0);             // zero position refused
        send_command(CMD_REGISTER, '1, '0);             // largest position, slot 0
        send_command(CMD_REGISTER, 64'd1, '0);          // new minimum, slot 1
        for (int k = 0; k < 8; k++)
            send_command(CMD_REGISTER, 64'd100 + 64'(k), '0);
        send_command(CMD_REGISTER, 64'd77, '0);         // table full
        send_command(CMD_UNREGISTER, '0, 4'd15);        // out of range
        send_command(CMD_UNREGISTER, '0, 4'd10);        // first index past the end
        send_command(CMD_UNREGISTER, '0, 4'd1);         // drops the minimum
        send_command(CMD_UNREGISTER, '0, 4'd1);         // slot already free
        send_command(CMD_UNUSED, '1, 4'd3);             // unused code acts as query
        send_command(CMD_REGISTER, 64'd5, '0);          // refills slot 1
        send_command(CMD_UNREGISTER, '0, 4'd9);         // last active slot
        send_command(CMD_UNREGISTER, '0, 4'd0);         // frees the largest
        send_command(CMD_QUERY, '1, 4'd15);
        wait_idle();

        // random phases: new slot count and a new pacing mode each time
        for (int p = 0; p < PHASES; p++) begin
            apb_write(ADDR_ACTIVE_SLOTS, {27'd0, settings[p]});
            book.active = settings[p];
            apb_read(ADDR_ACTIVE_SLOTS, readback);
            if (readback !== {27'd0, settings[p]}) begin
                $error("active_slots: expected %0d, got %0d", settings[p], readback);
                book.errors++;
            end
            mode = p % 4;
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            repeat (RANDOM_PER_PHASE) send_random_command();
            wait_idle();
        end

        $display("Sent %0d commands over %0d slot-count settings and four pacing modes.",
                 commands_sent, PHASES + 1);
        $display("%0d stored, %0d table full, %0d out of range, %0d zero; %0d results checked.",
                 book.stored, book.fulls, book.ranges, book.zeros, book.checked);
        if (book.errors == 0)
            $display("** slot_table_oldest_position_tracker_core: PASSED **");
        else
            $display("** slot_table_oldest_position_tracker_core: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/stopt_pkg.sv
rtl/stopt_cell.sv
rtl/slot_table_oldest_position_tracker_core.sv
tb/slot_table_oldest_position_tracker_core_test.sv
